### rtl/cfvos_pkg.sv
// Shared constants, codes and types of the central-force orbit stepper.
package cfvos_pkg;

  localparam int NUM_BODIES = 16;
  localparam int BODY_W     = 4;
  localparam int CNT_W      = 5;
  localparam int DATA_W     = 48;
  localparam int FRAC_BITS  = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int QUO_W      = 47;
  localparam int DIV_NUM_W  = 144;
  localparam int DIV_DEN_W  = 96;
  localparam int SQRT_STEPS = 48;
  localparam int ENTRY_W    = 6 * DATA_W;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] CFG_GRAV_PARAM = 2'd1;
  localparam logic [1:0] CFG_BODIES     = 2'd2;

  localparam logic [31:0] STEP_RESET   = 32'd11767448;
  localparam logic [46:0] GM_RESET     = 47'd169558586598;
  localparam logic [4:0]  BODIES_RESET = 5'd9;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_LAT, ST_GO, ST_MULW, ST_DIVW, ST_SQRT
  } state_t;

  // one body's update sequence
  typedef enum logic [4:0] {
    SP_DT2, SP_RD, SP_PVX, SP_PAX, SP_PVY, SP_PAY, SP_K1X, SP_K1Y,
    SP_SQX, SP_SQY, SP_SQRT, SP_DEN, SP_UX, SP_GX, SP_AX, SP_UY, SP_GY,
    SP_AY, SP_K2X, SP_K2Y, SP_WB
  } step_t;

endpackage

### rtl/cfvos_mul.sv
// Iterative 48x48 unsigned multiplier built from four 32x32 partial products.
module cfvos_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] a,
  input  logic [47:0] b,
  output logic        done,
  output logic [95:0] prod
);

  localparam logic [2:0] LAST_CNT = 3'd4;

  logic [47:0] a_r, b_r;
  logic [63:0] pp_r;
  logic [1:0]  psh_r;
  logic [95:0] acc_r;
  logic [2:0]  cnt_r;
  logic        run_r, done_r;
  logic [31:0] pa, pb;
  logic [1:0]  psh;

  // pick the partial product for this cycle
  always_comb begin
    case (cnt_r)
      3'd0: begin
        pa = a_r[31:0]; pb = b_r[31:0]; psh = 2'd0;
      end
      3'd1: begin
        pa = a_r[31:0]; pb = {16'd0, b_r[47:32]}; psh = 2'd1;
      end
      3'd2: begin
        pa = {16'd0, a_r[47:32]}; pb = b_r[31:0]; psh = 2'd1;
      end
      default: begin
        pa = {16'd0, a_r[47:32]}; pb = {16'd0, b_r[47:32]}; psh = 2'd2;
      end
    endcase
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == LAST_CNT) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // multiply, register, then accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r) begin
      pp_r  <= pa * pb;
      psh_r <= psh;
      if (cnt_r != 3'd0) begin
        acc_r <= acc_r + ({32'd0, pp_r} << {psh_r, 5'd0});
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### rtl/cfvos_div.sv
// Restoring divider, one quotient bit per cycle, with a quotient overflow flag.
module cfvos_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [143:0] num,
  input  logic [95:0]  den,
  output logic         done,
  output logic [46:0]  quo,
  output logic         ovf
);

  localparam logic [5:0] LAST_CNT = 6'(cfvos_pkg::QUO_W - 1);

  logic [143:0] rem_r, dsh_r;
  logic [46:0]  q_r;
  logic         ovf_r;
  logic [5:0]   cnt_r;
  logic         run_r, done_r;
  logic         take;

  assign take = (rem_r >= dsh_r);

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST_CNT) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // subtract the shifted divisor where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {2'd0, den, 46'd0};
      ovf_r <= (num >= {1'b0, den, 47'd0});
      q_r   <= '0;
    end else if (run_r) begin
      if (take) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[45:0], take};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign ovf  = ovf_r;

endmodule

### rtl/central_force_verlet_orbit_step.sv
// Top level of the central-force orbit stepper: state memory and update sequencer.
//
// Usage:
// - Input channel: an item is taken when start is high and busy is low.
//   in_kind selects a load (write one body's position and velocity, then
//   compute its acceleration) or a tick (advance every body in use).
// - Result channel: on a tick, one transaction per body, out_valid high for
//   a single cycle, body 0 first, out_last on the final body. A load gives
//   no result. The receiver cannot stall the block.
// - Configuration: cfg_valid with cfg_ready (always high) writes step size,
//   gravitational parameter or body count, selected by cfg_index.
// - Timing: a load or a tick keeps busy high until it is done; a body whose
//   radius is zero skips the divisions, and a tick with no bodies in use is
//   done at once. The 47-step divider (four divisions per body) and the
//   48-step square root dominate; one shared 48x48 multiplier serves all
//   products.
// - Results of a body leave the block the cycle after its update is
//   written back; the final one shows while busy is already low.
// - Reset: configuration returns to its defaults and all body state reads
//   as zero (per-entry valid bits), with no clearing pass.
module central_force_verlet_orbit_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [3:0]         in_body_index,
  input  logic signed [47:0] in_pos_x,
  input  logic signed [47:0] in_pos_y,
  input  logic signed [47:0] in_vel_x,
  input  logic signed [47:0] in_vel_y,
  output logic               out_valid,
  output logic [3:0]         out_body_id,
  output logic signed [47:0] out_cur_x,
  output logic signed [47:0] out_cur_y,
  output logic               out_singular,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [46:0]        cfg_data
);

  localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] NEG_MIN = {1'b1, 47'd0};

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    mag48 = v[47] ? 48'(-v) : 48'(v);
  endfunction

  // round to nearest by 2^32 or 2^33, saturate the magnitude
  function automatic logic [46:0] rnd_mag(input logic [95:0] p, input logic sh33);
    logic [96:0] s;
    logic [96:0] q;
    s = {1'b0, p} + (sh33 ? (97'd1 << 32) : (97'd1 << 31));
    q = sh33 ? (s >> 33) : (s >> 32);
    rnd_mag = (|q[96:47]) ? {47{1'b1}} : q[46:0];
  endfunction

  function automatic logic signed [47:0] apply_sign(input logic neg, input logic [46:0] m);
    apply_sign = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [47:0] sat_sum(input logic signed [47:0] a,
                                                 input logic signed [47:0] b,
                                                 input logic signed [47:0] c);
    logic [49:0] s;
    s = {{2{a[47]}}, a} + {{2{b[47]}}, b} + {{2{c[47]}}, c};
    if (s[49:47] == 3'b000 || s[49:47] == 3'b111) begin
      sat_sum = $signed(s[47:0]);
    end else begin
      sat_sum = s[49] ? NEG_MIN : POS_MAX;
    end
  endfunction

  // configuration
  logic [31:0] step_size_r;
  logic [46:0] grav_param_r;
  logic [4:0]  bodies_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= cfvos_pkg::STEP_RESET;
      grav_param_r <= cfvos_pkg::GM_RESET;
      bodies_r     <= cfvos_pkg::BODIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cfvos_pkg::CFG_STEP_SIZE:  step_size_r  <= cfg_data[31:0];
        cfvos_pkg::CFG_GRAV_PARAM: grav_param_r <= cfg_data;
        cfvos_pkg::CFG_BODIES:     bodies_r     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // state and working registers
  cfvos_pkg::state_t state_r, state_nxt;
  cfvos_pkg::step_t  step_r, step_nxt;

  logic signed [47:0] px_r, py_r, vx_r, vy_r, ax_r, ay_r;
  logic signed [47:0] px_nxt, py_nxt, vx_nxt, vy_nxt, ax_nxt, ay_nxt;
  logic signed [47:0] cx_r, cy_r, cx_nxt, cy_nxt, ta_r, ta_nxt;
  logic [95:0] sq_r, sq_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt, den_r, den_nxt;
  logic [5:0]  scnt_r, scnt_nxt;
  logic [47:0] r_r, r_nxt;
  logic [46:0] u_r, u_nxt;
  logic [79:0] g_r, g_nxt;
  logic [31:0] dt2_r, dt2_nxt;
  logic        sing_r, sing_nxt, load_r, load_nxt;
  logic [3:0]  body_r, body_nxt;
  logic [4:0]  nb_r, nb_nxt, nb_in;
  logic        last_body;

  logic [47:0] mx, my;
  logic [95:0] s_t;

  assign mx        = mag48(px_r);
  assign my        = mag48(py_r);
  assign nb_in     = (bodies_r > 5'(cfvos_pkg::NUM_BODIES)) ?
                     5'(cfvos_pkg::NUM_BODIES) : bodies_r;
  assign last_body = ({1'b0, body_r} + 5'd1 == nb_r);
  assign s_t       = sres_r + sbit_r;
  assign busy      = (state_r != cfvos_pkg::ST_IDLE);

  // memory of body state
  logic [cfvos_pkg::ENTRY_W-1:0] mem [cfvos_pkg::NUM_BODIES];
  logic [cfvos_pkg::ENTRY_W-1:0] rd_data_r;
  logic [cfvos_pkg::NUM_BODIES-1:0] vld_r;
  logic rd_vld_r;
  logic mem_we, mem_re, out_fire;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[body_r] <= {px_r, py_r, vx_r, vy_r, ax_r, ay_r};
    end
    if (mem_re) begin
      rd_data_r <= mem[body_r];
      rd_vld_r  <= vld_r[body_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[body_r] <= 1'b1;
    end
  end

  // shared arithmetic units
  logic         mul_start, mul_done, div_start, div_done, div_ovf;
  logic [47:0]  mul_a, mul_b;
  logic [95:0]  mul_p, div_den;
  logic [143:0] div_num;
  logic [46:0]  div_quo;

  cfvos_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  cfvos_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfvos_pkg::ST_IDLE: begin
        if (start) begin
          if (in_kind == cfvos_pkg::KIND_TICK) begin
            state_nxt = (nb_in != 5'd0) ? cfvos_pkg::ST_GO : cfvos_pkg::ST_IDLE;
          end else begin
            state_nxt = ({1'b0, in_body_index} < 5'(cfvos_pkg::NUM_BODIES)) ?
                        cfvos_pkg::ST_GO : cfvos_pkg::ST_IDLE;
          end
        end
      end
      cfvos_pkg::ST_GO: begin
        case (step_r)
          cfvos_pkg::SP_RD:   state_nxt = cfvos_pkg::ST_RD;
          cfvos_pkg::SP_SQRT: state_nxt = cfvos_pkg::ST_SQRT;
          cfvos_pkg::SP_UX, cfvos_pkg::SP_AX,
          cfvos_pkg::SP_UY, cfvos_pkg::SP_AY: state_nxt = cfvos_pkg::ST_DIVW;
          cfvos_pkg::SP_WB: begin
            state_nxt = (load_r || last_body) ? cfvos_pkg::ST_IDLE : cfvos_pkg::ST_RD;
          end
          default: state_nxt = cfvos_pkg::ST_MULW;
        endcase
      end
      cfvos_pkg::ST_RD:   state_nxt = cfvos_pkg::ST_LAT;
      cfvos_pkg::ST_LAT:  state_nxt = cfvos_pkg::ST_GO;
      cfvos_pkg::ST_MULW: if (mul_done) state_nxt = cfvos_pkg::ST_GO;
      cfvos_pkg::ST_DIVW: if (div_done) state_nxt = cfvos_pkg::ST_GO;
      cfvos_pkg::ST_SQRT: begin
        if (scnt_r == 6'(cfvos_pkg::SQRT_STEPS)) state_nxt = cfvos_pkg::ST_GO;
      end
      default: state_nxt = cfvos_pkg::ST_IDLE;
    endcase
  end

  // unit launches, memory strobes and operand selection
  always_comb begin
    mem_re    = (state_r == cfvos_pkg::ST_RD);
    mem_we    = (state_r == cfvos_pkg::ST_GO) && (step_r == cfvos_pkg::SP_WB);
    out_fire  = mem_we && !load_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    if (state_r == cfvos_pkg::ST_GO) begin
      case (step_r)
        cfvos_pkg::SP_RD, cfvos_pkg::SP_SQRT, cfvos_pkg::SP_WB: ;
        cfvos_pkg::SP_UX, cfvos_pkg::SP_AX,
        cfvos_pkg::SP_UY, cfvos_pkg::SP_AY: div_start = 1'b1;
        default: mul_start = 1'b1;
      endcase
    end
    case (step_r)
      cfvos_pkg::SP_DT2: begin
        mul_a = {16'd0, step_size_r}; mul_b = {16'd0, step_size_r};
      end
      cfvos_pkg::SP_PVX: begin mul_a = mag48(vx_r); mul_b = {16'd0, step_size_r}; end
      cfvos_pkg::SP_PAX: begin mul_a = mag48(ax_r); mul_b = {16'd0, dt2_r}; end
      cfvos_pkg::SP_PVY: begin mul_a = mag48(vy_r); mul_b = {16'd0, step_size_r}; end
      cfvos_pkg::SP_PAY: begin mul_a = mag48(ay_r); mul_b = {16'd0, dt2_r}; end
      cfvos_pkg::SP_K1X, cfvos_pkg::SP_K2X: begin
        mul_a = mag48(ax_r); mul_b = {16'd0, step_size_r};
      end
      cfvos_pkg::SP_K1Y, cfvos_pkg::SP_K2Y: begin
        mul_a = mag48(ay_r); mul_b = {16'd0, step_size_r};
      end
      cfvos_pkg::SP_SQX: begin mul_a = mx; mul_b = mx; end
      cfvos_pkg::SP_SQY: begin mul_a = my; mul_b = my; end
      cfvos_pkg::SP_DEN: begin mul_a = r_r; mul_b = r_r; end
      default: begin mul_a = {1'b0, grav_param_r}; mul_b = {1'b0, u_r}; end
    endcase
    case (step_r)
      cfvos_pkg::SP_UX: begin
        div_num = ({96'd0, mx} << cfvos_pkg::FRAC_BITS) + {97'd0, r_r[47:1]};
        div_den = {48'd0, r_r};
      end
      cfvos_pkg::SP_UY: begin
        div_num = ({96'd0, my} << cfvos_pkg::FRAC_BITS) + {97'd0, r_r[47:1]};
        div_den = {48'd0, r_r};
      end
      default: begin
        div_num = ({64'd0, g_r} << cfvos_pkg::FRAC_BITS) + {49'd0, den_r[95:1]};
        div_den = den_r;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    step_nxt = step_r;
    px_nxt = px_r; py_nxt = py_r; vx_nxt = vx_r; vy_nxt = vy_r;
    ax_nxt = ax_r; ay_nxt = ay_r; cx_nxt = cx_r; cy_nxt = cy_r; ta_nxt = ta_r;
    sq_nxt = sq_r; sres_nxt = sres_r; sbit_nxt = sbit_r; scnt_nxt = scnt_r;
    den_nxt = den_r; r_nxt = r_r; u_nxt = u_r; g_nxt = g_r; dt2_nxt = dt2_r;
    sing_nxt = sing_r; load_nxt = load_r; body_nxt = body_r; nb_nxt = nb_r;
    case (state_r)
      cfvos_pkg::ST_IDLE: begin
        if (start) begin
          load_nxt = (in_kind == cfvos_pkg::KIND_LOAD);
          nb_nxt   = nb_in;
          if (in_kind == cfvos_pkg::KIND_TICK) begin
            body_nxt = '0;
            step_nxt = cfvos_pkg::SP_DT2;
          end else begin
            body_nxt = in_body_index;
            px_nxt = in_pos_x; py_nxt = in_pos_y;
            vx_nxt = in_vel_x; vy_nxt = in_vel_y;
            step_nxt = cfvos_pkg::SP_SQX;
          end
        end
      end
      cfvos_pkg::ST_LAT: begin
        if (rd_vld_r) begin
          {px_nxt, py_nxt, vx_nxt, vy_nxt, ax_nxt, ay_nxt} = rd_data_r;
          cx_nxt = rd_data_r[287:240];
          cy_nxt = rd_data_r[239:192];
        end else begin
          {px_nxt, py_nxt, vx_nxt, vy_nxt, ax_nxt, ay_nxt} = '0;
          cx_nxt = '0;
          cy_nxt = '0;
        end
        sing_nxt = 1'b0;
        step_nxt = cfvos_pkg::SP_PVX;
      end
      cfvos_pkg::ST_GO: begin
        if (step_r == cfvos_pkg::SP_SQRT) begin
          sres_nxt = '0;
          sbit_nxt = 96'd1 << 94;
          scnt_nxt = '0;
        end
        if (step_r == cfvos_pkg::SP_WB && !load_r && !last_body) begin
          body_nxt = body_r + 4'd1;
        end
      end
      cfvos_pkg::ST_MULW: begin
        if (mul_done) begin
          case (step_r)
            cfvos_pkg::SP_DT2: begin
              dt2_nxt  = 32'(rnd_mag(mul_p, 1'b0));
              step_nxt = cfvos_pkg::SP_RD;
            end
            cfvos_pkg::SP_PVX: begin
              ta_nxt   = apply_sign(vx_r[47], rnd_mag(mul_p, 1'b0));
              step_nxt = cfvos_pkg::SP_PAX;
            end
            cfvos_pkg::SP_PAX: begin
              px_nxt   = sat_sum(px_r, ta_r, apply_sign(ax_r[47], rnd_mag(mul_p, 1'b1)));
              step_nxt = cfvos_pkg::SP_PVY;
            end
            cfvos_pkg::SP_PVY: begin
              ta_nxt   = apply_sign(vy_r[47], rnd_mag(mul_p, 1'b0));
              step_nxt = cfvos_pkg::SP_PAY;
            end
            cfvos_pkg::SP_PAY: begin
              py_nxt   = sat_sum(py_r, ta_r, apply_sign(ay_r[47], rnd_mag(mul_p, 1'b1)));
              step_nxt = cfvos_pkg::SP_K1X;
            end
            cfvos_pkg::SP_K1X, cfvos_pkg::SP_K2X: begin
              vx_nxt   = sat_sum(vx_r, apply_sign(ax_r[47], rnd_mag(mul_p, 1'b1)), '0);
              step_nxt = (step_r == cfvos_pkg::SP_K1X) ? cfvos_pkg::SP_K1Y : cfvos_pkg::SP_K2Y;
            end
            cfvos_pkg::SP_K1Y, cfvos_pkg::SP_K2Y: begin
              vy_nxt   = sat_sum(vy_r, apply_sign(ay_r[47], rnd_mag(mul_p, 1'b1)), '0);
              step_nxt = (step_r == cfvos_pkg::SP_K1Y) ? cfvos_pkg::SP_SQX : cfvos_pkg::SP_WB;
            end
            cfvos_pkg::SP_SQX: begin
              sq_nxt   = mul_p;
              step_nxt = cfvos_pkg::SP_SQY;
            end
            cfvos_pkg::SP_SQY: begin
              sq_nxt   = sq_r + mul_p;
              step_nxt = cfvos_pkg::SP_SQRT;
            end
            cfvos_pkg::SP_DEN: begin
              den_nxt  = mul_p;
              step_nxt = cfvos_pkg::SP_UX;
            end
            cfvos_pkg::SP_GX: begin
              g_nxt    = mul_p[79:0];
              step_nxt = cfvos_pkg::SP_AX;
            end
            cfvos_pkg::SP_GY: begin
              g_nxt    = mul_p[79:0];
              step_nxt = cfvos_pkg::SP_AY;
            end
            default: step_nxt = cfvos_pkg::SP_WB;
          endcase
        end
      end
      cfvos_pkg::ST_DIVW: begin
        if (div_done) begin
          case (step_r)
            cfvos_pkg::SP_UX: begin
              u_nxt    = div_quo;
              step_nxt = cfvos_pkg::SP_GX;
            end
            cfvos_pkg::SP_UY: begin
              u_nxt    = div_quo;
              step_nxt = cfvos_pkg::SP_GY;
            end
            cfvos_pkg::SP_AX: begin
              ax_nxt   = apply_sign(!px_r[47], div_ovf ? {47{1'b1}} : div_quo);
              step_nxt = cfvos_pkg::SP_UY;
            end
            default: begin
              ay_nxt   = apply_sign(!py_r[47], div_ovf ? {47{1'b1}} : div_quo);
              step_nxt = load_r ? cfvos_pkg::SP_WB : cfvos_pkg::SP_K2X;
            end
          endcase
        end
      end
      cfvos_pkg::ST_SQRT: begin
        if (scnt_r != 6'(cfvos_pkg::SQRT_STEPS)) begin
          // one result bit per cycle
          if (sq_r >= s_t) begin
            sq_nxt   = sq_r - s_t;
            sres_nxt = (sres_r >> 1) + sbit_r;
          end else begin
            sres_nxt = sres_r >> 1;
          end
          sbit_nxt = sbit_r >> 2;
          scnt_nxt = scnt_r + 6'd1;
        end else begin
          r_nxt = sres_r[47:0];
          if (sres_r[47:0] == 48'd0) begin
            ax_nxt   = '0;
            ay_nxt   = '0;
            sing_nxt = 1'b1;
            step_nxt = load_r ? cfvos_pkg::SP_WB : cfvos_pkg::SP_K2X;
          end else begin
            step_nxt = cfvos_pkg::SP_DEN;
          end
        end
      end
      default: ;
    endcase
  end

  // payload registers
  logic        out_valid_r;
  logic [3:0]  out_id_r;
  logic [47:0] out_x_r, out_y_r;
  logic        out_sing_r, out_last_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfvos_pkg::ST_IDLE;
      step_r      <= cfvos_pkg::SP_DT2;
      load_r      <= 1'b0;
      body_r      <= '0;
      nb_r        <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      load_r      <= load_nxt;
      body_r      <= body_nxt;
      nb_r        <= nb_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_fire;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt; py_r <= py_nxt; vx_r <= vx_nxt; vy_r <= vy_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
    ta_r <= ta_nxt; sq_r <= sq_nxt; sres_r <= sres_nxt; sbit_r <= sbit_nxt;
    den_r <= den_nxt; r_r <= r_nxt; u_r <= u_nxt; g_r <= g_nxt;
    dt2_r <= dt2_nxt; sing_r <= sing_nxt;
    if (out_fire) begin
      out_id_r   <= body_r;
      out_x_r    <= cx_r;
      out_y_r    <= cy_r;
      out_sing_r <= sing_r;
      out_last_r <= last_body;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_body_id  = out_id_r;
  assign out_cur_x    = out_x_r;
  assign out_cur_y    = out_y_r;
  assign out_singular = out_sing_r;
  assign out_last     = out_last_r;

endmodule

### rtl/cfvos_chk.sv
// Port-level checks of the orbit stepper, bound to the top level.
module cfvos_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_kind,
  input logic out_valid,
  input logic out_last
);

  // results of one tick never come in back-to-back cycles
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // a load always occupies the block
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == cfvos_pkg::KIND_LOAD) |=> busy)
    else $error("load transaction not taken up");

  // the final result of a tick leaves the block idle
  assert property (@(posedge clk) disable iff (!rst_n) out_valid && out_last |-> !busy)
    else $error("busy after final result");

  // any earlier result comes while the tick is still running
  assert property (@(posedge clk) disable iff (!rst_n) out_valid && !out_last |-> busy)
    else $error("idle before final result");

endmodule

bind central_force_verlet_orbit_step cfvos_chk u_cfvos_chk (.*);
